>>> sv/sha1_pkg.sv
// shared types and constants for the sha-1 engine
package sha1_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;
   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;
   localparam logic [7:0]  PadByte = 8'h80;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_FINAL  = 1'b1
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } state_type;

   function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
      rol = (x << n) | (x >> (32 - n));
   endfunction

endpackage

>>> sv/sha1_front.sv
// input command queue between the request port and the compression engine
module sha1_front
   import sha1_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepth
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     not_empty,
   output item_type head_item
);
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   item_type         mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_in  = push ? bump(wr_ff) : wr_ff;
      rd_in  = pop ? bump(rd_ff) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= push_item;
   end

   assign full      = (cnt_ff == (AW+1)'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head_item = mem_ff[rd_ff];
endmodule

>>> sv/sha1_back.sv
// block buffer, padding sequencer and iterative sha-1 round unit
module sha1_back
   import sha1_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        item_valid,
   input  item_type    item,
   output logic        item_pop,
   output logic        idle,
   output logic        rsp_valid,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   state_type    state_ff, state_in, state_q;
   logic [31:0]  buf_ff [16];
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  total_ff, total_in;
   logic [31:0]  h_ff [5];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]  w_ff [16];
   logic [6:0]   rnd_ff, rnd_in;
   logic         fin_ff, fin_in;
   logic         wr_en;
   logic [5:0]   wr_addr;
   logic [7:0]   wr_data;
   logic [2:0]   idx_ff, idx_in;
   logic [63:0]  bits;
   logic [31:0]  f, k, t, wn;
   logic         need_second;
   logic         bits_done_ff, bits_done_in;
   logic         len_ok_ff, len_ok_in;
   logic [7:0]   pad_data;

   assign bits = {total_ff, 3'b000};

   always_comb begin
      if (rnd_ff < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff); k = K0;
      end else if (rnd_ff < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff; k = K1;
      end else if (rnd_ff < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff); k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff; k = K3;
      end
      t  = rol(a_ff, 5) + f + e_ff + k + w_ff[0];
      wn = rol(w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0], 1);
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      total_in = total_ff;
      rnd_in   = rnd_ff;
      fin_in   = fin_ff;
      idx_in   = idx_ff;
      item_pop = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = fill_ff;
      wr_data  = item.data;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               wr_en    = 1'b1;
               fin_in   = (item.op == OP_FINAL);
               if (item.op == OP_FINAL) wr_data = PadByte;
               else total_in = total_ff + 61'd1;
               fill_in = fill_ff + 6'd1;
               if (fill_ff == 6'd63) state_in = ST_LOAD;
               else if (item.op == OP_FINAL) state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (fill_ff >= 6'd56) wr_data = bits[{~fill_ff[2:0], 3'b000} +: 8];
            else wr_data = 8'h00;
            fill_in = fill_ff + 6'd1;
            if (fill_ff == 6'd63) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd15) begin
               rnd_in = '0; state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            rnd_in = rnd_ff + 7'd1;
            if (rnd_ff == 7'd79) begin
               rnd_in = '0; state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            if (fin_ff) begin
               idx_in = '0; state_in = ST_EMIT;
            end else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            idx_in = idx_ff + 3'd1;
            if (idx_ff == 3'd4) begin
               state_in = ST_IDLE; fin_in = 1'b0; idx_in = '0;
               fill_in = '0; total_in = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // a finalize without room for the length needs a second block
   assign need_second = fin_ff && (state_ff == ST_ADD) && !bits_done_ff;

   always_comb begin
      bits_done_in = bits_done_ff;
      if (state_ff == ST_IDLE) bits_done_in = 1'b0;
      if (state_ff == ST_PAD && fill_ff == 6'd63 && len_ok_ff) bits_done_in = 1'b1;
   end

   always_comb begin
      len_ok_in = len_ok_ff;
      if (state_ff == ST_IDLE && item_valid && item.op == OP_FINAL)
         len_ok_in = (fill_ff < 6'd56);
      else if (need_second) len_ok_in = 1'b1;
   end

   always_comb begin
      state_q = state_in;
      if (need_second) state_q = ST_PAD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         total_ff    <= '0;
         rnd_ff      <= '0;
         fin_ff      <= 1'b0;
         idx_ff      <= '0;
         bits_done_ff <= 1'b0;
         len_ok_ff   <= 1'b0;
         h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
      end else begin
         state_ff    <= state_q;
         fill_ff     <= fill_in;
         total_ff    <= total_in;
         rnd_ff      <= rnd_in;
         fin_ff      <= fin_in;
         idx_ff      <= idx_in;
         bits_done_ff <= bits_done_in;
         len_ok_ff   <= len_ok_in;
         if (state_ff == ST_ADD) begin
            h_ff[0] <= h_ff[0] + a_ff; h_ff[1] <= h_ff[1] + b_ff;
            h_ff[2] <= h_ff[2] + c_ff; h_ff[3] <= h_ff[3] + d_ff;
            h_ff[4] <= h_ff[4] + e_ff;
         end
         if (state_ff == ST_EMIT && idx_ff == 3'd4) begin
            h_ff[0] <= H0; h_ff[1] <= H1; h_ff[2] <= H2; h_ff[3] <= H3; h_ff[4] <= H4;
         end
      end
   end

   always_comb begin
      pad_data = wr_data;
      if (state_ff == ST_PAD && !(len_ok_ff && fill_ff >= 6'd56)) pad_data = 8'h00;
   end

   always_ff @(posedge clock) begin
      if (wr_en) buf_ff[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= pad_data;
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= buf_ff[rnd_ff[3:0]];
         a_ff <= h_ff[0]; b_ff <= h_ff[1]; c_ff <= h_ff[2];
         d_ff <= h_ff[3]; e_ff <= h_ff[4];
      end else if (state_ff == ST_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wn;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= rol(b_ff, 30);
         b_ff <= a_ff; a_ff <= t;
      end
   end

   assign idle            = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd4);
endmodule

>>> sv/sha1_hash_engine_core.sv
// top level of the byte-serial sha-1 engine
// usage:
//   drive req_opcode/req_data_byte with start; the transfer happens when
//   start is high and busy is low. opcode 0 absorbs a byte, opcode 1 ends
//   the message and returns five digest words on rsp_ with rsp_valid high
//   for one cycle each, word 0 first, rsp_last_word on word 4.
// a small command queue in front lets bytes arrive while a block is being
// compressed; busy is high only while the queue is full.
// the back end writes each absorbed byte into the block buffer; every 64th
// byte starts the schedule load, 80 rounds and the chaining add in the
// single shared round unit, and no byte is taken until they are done.
// finalize runs the padding sweep plus one or two compressions and then
// returns the five result words.
// synchronous reset empties the queue and returns to the initial chaining
// value with an empty message. results cannot be held off by the receiver.
module sha1_hash_engine_core
   import sha1_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   item_type in_item, head;
   logic     full, not_empty, pop, idle, push;

   assign in_item = '{op: op_type'(req_opcode), data: req_data_byte};
   assign busy    = full;
   assign push    = start && !full;

   sha1_front #(.DEPTH(QUEUE_DEPTH)) u_front (
      .clock, .reset, .push, .push_item(in_item), .full,
      .pop, .not_empty, .head_item(head)
   );

   sha1_back u_back (
      .clock, .reset, .item_valid(not_empty), .item(head), .item_pop(pop), .idle,
      .rsp_valid, .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |-> rsp_word_index == 3'd4) else $error("last flag");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> idle && not_empty) else $error("pop outside idle");
   a_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> rsp_valid) else $error("digest burst broken");
endmodule

>>> dv/testbench.sv
// self-checking testbench for the byte-serial sha-1 engine
`timescale 1ns / 1ps

module testbench
   import sha1_pkg::*;
;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       has_digest;
      logic [31:0] digest0;
   } stim_row_type;

   localparam int WatchdogLimit = 20000;
   localparam int MaxReports = 10;
   localparam int DrainCycles = 300;
   localparam int ItemTarget = 170;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_opcode;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   logic [31:0] chain [5];
   logic [7:0]  block_bytes [64];
   int unsigned fill;
   logic [60:0] total_bytes;

   logic [31:0] digest_queue [$];
   logic [2:0]  index_queue [$];
   logic        last_queue [$];

   int          mismatches;
   int          known_errors;
   int          items_sent;
   int          idle_cycles;
   bit          timed_out;
   bit          no_gaps;

   sha1_hash_engine_core dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_data_byte(req_data_byte),
      .rsp_valid(rsp_valid),
      .rsp_digest_word(rsp_digest_word),
      .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   task automatic clear_hash();
      chain[0] = H0; chain[1] = H1; chain[2] = H2; chain[3] = H3; chain[4] = H4;
      for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      fill = 0;
      total_bytes = '0;
   endtask

   task automatic compress_block();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++)
         w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d); k = K0;
         end else if (i < 40) begin
            f = b ^ c ^ d; k = K1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K2;
         end else begin
            f = b ^ c ^ d; k = K3;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
   endtask

   task automatic predict_digest(input op_type op, input logic [7:0] data);
      logic [63:0] bit_length;
      if (op == OP_ABSORB) begin
         block_bytes[fill] = data;
         fill++;
         total_bytes++;
         if (fill == 64) begin
            compress_block();
            fill = 0;
         end
      end else begin
         bit_length = {total_bytes, 3'b000};
         block_bytes[fill] = PadByte;
         fill++;
         if (fill > 56) begin
            while (fill < 64) block_bytes[fill++] = 8'h00;
            compress_block();
            fill = 0;
         end
         while (fill < 56) block_bytes[fill++] = 8'h00;
         for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_length[63-8*i -: 8];
         compress_block();
         for (int i = 0; i < 5; i++) begin
            digest_queue.push_back(chain[i]);
            index_queue.push_back(3'(i));
            last_queue.push_back(i == 4);
         end
         clear_hash();
      end
   endtask

   task automatic send_item(input op_type op, input logic [7:0] data);
      if (!no_gaps)
         while ($urandom_range(99) < 13) begin
            start <= 1'b0;
            req_data_byte <= 8'($urandom);
            @(negedge clock);
         end
      start <= 1'b1;
      req_opcode <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_digest(op, data);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_message(input int n_bytes, input bit ones);
      for (int i = 0; i < n_bytes; i++)
         send_item(OP_ABSORB, ones ? 8'hff : 8'($urandom));
      send_item(OP_FINAL, 8'($urandom));
   endtask

   always @(posedge clock) begin
      if (reset || start && !busy || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WatchdogLimit && !timed_out) begin
         timed_out = 1'b1;
         $display("FAIL sha1_hash_engine_core");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (digest_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports)
               $display("unexpected digest transfer word %0d = %h",
                        rsp_word_index, rsp_digest_word);
         end else begin
            if (rsp_digest_word !== digest_queue[0] || rsp_word_index !== index_queue[0]
                || rsp_last_word !== last_queue[0]) begin
               mismatches++;
               if (mismatches <= MaxReports)
                  $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                           digest_queue[0], index_queue[0], last_queue[0],
                           rsp_digest_word, rsp_word_index, rsp_last_word);
            end
            void'(digest_queue.pop_front());
            void'(index_queue.pop_front());
            void'(last_queue.pop_front());
         end
      end
   end

   stim_row_type directed [] = '{
      '{OP_FINAL,  8'hff, 1'b1, 32'hda39a3ee},
      '{OP_FINAL,  8'h00, 1'b1, 32'hda39a3ee},
      '{OP_ABSORB, 8'h61, 1'b0, 32'h0},
      '{OP_ABSORB, 8'h62, 1'b0, 32'h0},
      '{OP_ABSORB, 8'h63, 1'b0, 32'h0},
      '{OP_FINAL,  8'h00, 1'b1, 32'ha9993e36},
      '{OP_ABSORB, 8'h00, 1'b0, 32'h0},
      '{OP_ABSORB, 8'hff, 1'b0, 32'h0},
      '{OP_ABSORB, 8'haa, 1'b0, 32'h0},
      '{OP_ABSORB, 8'h55, 1'b0, 32'h0},
      '{OP_FINAL,  8'h5a, 1'b0, 32'h0}
   };

   initial begin
      int len;
      known_errors = 0;
      items_sent = 0;
      no_gaps = 1'b0;
      start = 1'b0;
      req_opcode = OP_ABSORB;
      req_data_byte = 8'h00;
      reset = 1'b1;
      clear_hash();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         send_item(directed[i].op, directed[i].data);
         if (directed[i].has_digest && digest_queue.size() >= 5
             && digest_queue[digest_queue.size()-5] !== directed[i].digest0) begin
            known_errors++;
            $display("known digest mismatch row %0d", i);
         end
      end

      // length that forces the extra padding block
      send_message(56, 1'b0);

      no_gaps = 1'b1;
      send_message(64, 1'b1);
      no_gaps = 1'b0;
      while (items_sent < ItemTarget) begin
         case ($urandom_range(3))
            0: len = 0;
            1: len = $urandom_range(3);
            default: len = $urandom_range(12);
         endcase
         send_message(len, 1'b0);
      end
      start <= 1'b0;

      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatches == 0 && known_errors == 0) begin
         $display("PASS sha1_hash_engine_core");
      end else begin
         $display("FAIL sha1_hash_engine_core");
      end
      $finish;
   end

endmodule

>>> filelist.f
sv/sha1_pkg.sv
sv/sha1_front.sv
sv/sha1_back.sv
sv/sha1_hash_engine_core.sv
dv/testbench.sv
